// ===== sv/rds_pkg.sv =====
package rds_pkg;

    // Coordinates carried from the front part to the back part.
    localparam int unsigned NUM_COORDS = 8;
    localparam int unsigned COORD_IDX_BITS = 3;

    localparam logic [COORD_IDX_BITS-1:0] C_BASE_LEFT   = 3'd0;
    localparam logic [COORD_IDX_BITS-1:0] C_BASE_TOP    = 3'd1;
    localparam logic [COORD_IDX_BITS-1:0] C_BASE_RIGHT  = 3'd2;
    localparam logic [COORD_IDX_BITS-1:0] C_BASE_BOTTOM = 3'd3;
    localparam logic [COORD_IDX_BITS-1:0] C_OVL_LEFT    = 3'd4;
    localparam logic [COORD_IDX_BITS-1:0] C_OVL_TOP     = 3'd5;
    localparam logic [COORD_IDX_BITS-1:0] C_OVL_RIGHT   = 3'd6;
    localparam logic [COORD_IDX_BITS-1:0] C_OVL_BOTTOM  = 3'd7;

    // Bands in emission order.
    localparam int unsigned NUM_BANDS = 4;
    localparam int unsigned BAND_TOP    = 0;
    localparam int unsigned BAND_LEFT   = 1;
    localparam int unsigned BAND_RIGHT  = 2;
    localparam int unsigned BAND_BOTTOM = 3;

    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef logic [NUM_BANDS-1:0] band_mask_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_BASE  = 2'd1,
        KIND_SPLIT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        band_mask_t bands;
    } cls_t;

endpackage

// ===== sv/rds_pair_if.sv =====
interface rds_pair_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] base_left;
    logic signed [COORD_BITS-1:0] base_top;
    logic signed [COORD_BITS-1:0] base_right;
    logic signed [COORD_BITS-1:0] base_bottom;
    logic signed [COORD_BITS-1:0] cut_left;
    logic signed [COORD_BITS-1:0] cut_top;
    logic signed [COORD_BITS-1:0] cut_right;
    logic signed [COORD_BITS-1:0] cut_bottom;

    modport source (
        output valid, base_left, base_top, base_right, base_bottom,
               cut_left, cut_top, cut_right, cut_bottom,
        input  ready
    );

    modport sink (
        input  valid, base_left, base_top, base_right, base_bottom,
               cut_left, cut_top, cut_right, cut_bottom,
        output ready
    );
endinterface

// ===== sv/rds_piece_if.sv =====
interface rds_piece_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] piece_left;
    logic signed [COORD_BITS-1:0] piece_top;
    logic signed [COORD_BITS-1:0] piece_right;
    logic signed [COORD_BITS-1:0] piece_bottom;
    logic                         piece_valid;
    logic                         last_piece;

    modport source (
        output valid, piece_left, piece_top, piece_right, piece_bottom,
               piece_valid, last_piece,
        input  ready
    );

    modport sink (
        input  valid, piece_left, piece_top, piece_right, piece_bottom,
               piece_valid, last_piece,
        output ready
    );
endinterface

// ===== sv/rds_front.sv =====
module rds_front #(
    parameter int COORD_BITS = 16
) (
    rds_pair_if.sink                                     pair,
    input  logic                                         q_ready,
    output logic                                         q_push,
    output logic [rds_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] q_coords,
    output rds_pkg::cls_t                                q_cls
);
    import rds_pkg::*;

    logic signed [COORD_BITS-1:0] bl, bt, br, bb;
    logic signed [COORD_BITS-1:0] cl, ct, cr, cb;
    logic signed [COORD_BITS-1:0] il, it, ir, ib;
    logic                         contained;
    logic                         no_overlap;
    band_mask_t                   bands;

    assign bl = pair.base_left;
    assign bt = pair.base_top;
    assign br = pair.base_right;
    assign bb = pair.base_bottom;
    assign cl = pair.cut_left;
    assign ct = pair.cut_top;
    assign cr = pair.cut_right;
    assign cb = pair.cut_bottom;

    assign il = (bl > cl) ? bl : cl;
    assign it = (bt > ct) ? bt : ct;
    assign ir = (br < cr) ? br : cr;
    assign ib = (bb < cb) ? bb : cb;

    assign contained  = (cl <= bl) && (ct <= bt) && (br <= cr) && (bb <= cb);
    assign no_overlap = (ir <= il) || (ib <= it) || (cr == cl) || (cb == ct);

    always_comb
    begin
        bands              = '0;
        bands[BAND_TOP]    = bt < it;
        bands[BAND_LEFT]   = bl < il;
        bands[BAND_RIGHT]  = br > ir;
        bands[BAND_BOTTOM] = bb > ib;
    end

    always_comb
    begin
        q_cls.bands = bands;
        if (contained || (!no_overlap && bands == '0))
        begin
            q_cls.kind = KIND_NONE;
        end
        else if (no_overlap)
        begin
            q_cls.kind = KIND_BASE;
        end
        else
        begin
            q_cls.kind = KIND_SPLIT;
        end
    end

    always_comb
    begin
        q_coords                = '0;
        q_coords[C_BASE_LEFT]   = $unsigned(bl);
        q_coords[C_BASE_TOP]    = $unsigned(bt);
        q_coords[C_BASE_RIGHT]  = $unsigned(br);
        q_coords[C_BASE_BOTTOM] = $unsigned(bb);
        q_coords[C_OVL_LEFT]    = $unsigned(il);
        q_coords[C_OVL_TOP]     = $unsigned(it);
        q_coords[C_OVL_RIGHT]   = $unsigned(ir);
        q_coords[C_OVL_BOTTOM]  = $unsigned(ib);
    end

    assign pair.ready = q_ready;
    assign q_push     = pair.valid && q_ready;

endmodule

// ===== sv/rds_queue.sv =====
module rds_queue #(
    parameter int COORD_BITS = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           push,
    input  logic [rds_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] push_coords,
    input  rds_pkg::cls_t                                  push_cls,
    output logic                                           can_push,
    input  logic                                           pop,
    output logic                                           head_valid,
    output logic [rds_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] head_coords,
    output rds_pkg::cls_t                                  head_cls
);
    import rds_pkg::*;

    logic [NUM_COORDS-1:0][COORD_BITS-1:0] coords_mem [QUEUE_DEPTH];
    cls_t                                  cls_mem    [QUEUE_DEPTH];

    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg,  count_next;

    assign can_push    = count_reg != QUEUE_PTR_BITS'(0) + (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign head_valid  = count_reg != '0;
    assign head_coords = coords_mem[rd_ptr_reg];
    assign head_cls    = cls_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            coords_mem[wr_ptr_reg] <= push_coords;
            cls_mem[wr_ptr_reg]    <= push_cls;
        end
    end

endmodule

// ===== sv/rds_back.sv =====
module rds_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           head_valid,
    input  logic [rds_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] head_coords,
    input  rds_pkg::cls_t                                  head_cls,
    output logic                                           pop,
    rds_piece_if.source                                    piece
);
    import rds_pkg::*;

    band_mask_t done_reg, done_next;
    band_mask_t pending;
    band_mask_t sel;
    logic       last;
    logic       load;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [COORD_BITS-1:0] left_next, top_next, right_next, bottom_next;
    logic                  pvalid_reg, pvalid_next;
    logic                  last_reg, last_next;

    assign pending = head_cls.bands & ~done_reg;
    // Lowest pending band goes first, which gives top, left, right, bottom order.
    assign sel     = pending & (~pending + 1'b1);

    always_comb
    begin
        left_next   = '0;
        top_next    = '0;
        right_next  = '0;
        bottom_next = '0;
        pvalid_next = 1'b0;
        last_next   = 1'b1;
        unique case (head_cls.kind)
            KIND_NONE:
            begin
                pvalid_next = 1'b0;
            end
            KIND_BASE:
            begin
                pvalid_next = 1'b1;
                left_next   = head_coords[C_BASE_LEFT];
                top_next    = head_coords[C_BASE_TOP];
                right_next  = head_coords[C_BASE_RIGHT];
                bottom_next = head_coords[C_BASE_BOTTOM];
            end
            KIND_SPLIT:
            begin
                pvalid_next = 1'b1;
                last_next   = (pending & ~sel) == '0;
                if (sel[BAND_TOP])
                begin
                    left_next   = head_coords[C_BASE_LEFT];
                    top_next    = head_coords[C_BASE_TOP];
                    right_next  = head_coords[C_BASE_RIGHT];
                    bottom_next = head_coords[C_OVL_TOP];
                end
                else if (sel[BAND_LEFT])
                begin
                    left_next   = head_coords[C_BASE_LEFT];
                    top_next    = head_coords[C_OVL_TOP];
                    right_next  = head_coords[C_OVL_LEFT];
                    bottom_next = head_coords[C_OVL_BOTTOM];
                end
                else if (sel[BAND_RIGHT])
                begin
                    left_next   = head_coords[C_OVL_RIGHT];
                    top_next    = head_coords[C_OVL_TOP];
                    right_next  = head_coords[C_BASE_RIGHT];
                    bottom_next = head_coords[C_OVL_BOTTOM];
                end
                else
                begin
                    left_next   = head_coords[C_BASE_LEFT];
                    top_next    = head_coords[C_OVL_BOTTOM];
                    right_next  = head_coords[C_BASE_RIGHT];
                    bottom_next = head_coords[C_BASE_BOTTOM];
                end
            end
            default:
            begin
                pvalid_next = 1'b0;
            end
        endcase
    end

    assign last = last_next;
    assign load = head_valid && (!out_valid_reg || piece.ready);
    assign pop  = load && last;

    always_comb
    begin
        done_next = done_reg;
        if (pop)
        begin
            done_next = '0;
        end
        else if (load)
        begin
            done_next = done_reg | sel;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (piece.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            pvalid_reg <= pvalid_next;
            last_reg   <= last_next;
        end
    end

    assign piece.valid        = out_valid_reg;
    assign piece.piece_left   = $signed(left_reg);
    assign piece.piece_top    = $signed(top_reg);
    assign piece.piece_right  = $signed(right_reg);
    assign piece.piece_bottom = $signed(bottom_reg);
    assign piece.piece_valid  = pvalid_reg;
    assign piece.last_piece   = last_reg;

endmodule

// ===== sv/rectangle_difference_splitter_unit.sv =====
// Channel  Modport  Transfer
// pair     sink     base and cutter rectangle, one per item
// piece    source   one remaining rectangle or none, last_piece marks the final one
//
// An item gives one to four pieces; the back part sends one piece per cycle while
// the piece sink is ready. An accepted pair is written into the queue, and its
// first piece is then loaded into the back part's output register.
// The front part takes a pair whenever the four-entry queue has room.
// rst_n asynchronously clears the queue pointers, the band state and the output valid flag.
// A stalled piece holds its register; the queue keeps filling behind it.
module rectangle_difference_splitter_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rds_pair_if.sink    pair,
    rds_piece_if.source piece
);
    import rds_pkg::*;

    logic                                  q_push;
    logic                                  q_can_push;
    logic [NUM_COORDS-1:0][COORD_BITS-1:0] q_push_coords;
    cls_t                                  q_push_cls;
    logic                                  q_pop;
    logic                                  q_head_valid;
    logic [NUM_COORDS-1:0][COORD_BITS-1:0] q_head_coords;
    cls_t                                  q_head_cls;

    rds_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .pair     (pair),
        .q_ready  (q_can_push),
        .q_push   (q_push),
        .q_coords (q_push_coords),
        .q_cls    (q_push_cls)
    );

    rds_queue #(
        .COORD_BITS (COORD_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_coords (q_push_coords),
        .push_cls    (q_push_cls),
        .can_push    (q_can_push),
        .pop         (q_pop),
        .head_valid  (q_head_valid),
        .head_coords (q_head_coords),
        .head_cls    (q_head_cls)
    );

    rds_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_coords (q_head_coords),
        .head_cls    (q_head_cls),
        .pop         (q_pop),
        .piece       (piece)
    );

endmodule

// ===== verif/rectangle_difference_splitter_unit_tb.sv =====
module rectangle_difference_splitter_unit_tb;

    localparam int COORD_BITS = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t base_left;
        coord_t base_top;
        coord_t base_right;
        coord_t base_bottom;
        coord_t cut_left;
        coord_t cut_top;
        coord_t cut_right;
        coord_t cut_bottom;
    } rect_pair_t;

    typedef struct {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        logic   filled;
        logic   last;
    } piece_t;

    class rect_split_scoreboard;
        piece_t pending_pieces[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void add_expected(piece_t p);
            pending_pieces.insert(pending_pieces.size(), p);
        endfunction

        function piece_t make_piece(logic filled, int l, int t, int r, int b);
            piece_t p;
            p.filled = filled;
            p.left   = filled ? coord_t'(l) : '0;
            p.top    = filled ? coord_t'(t) : '0;
            p.right  = filled ? coord_t'(r) : '0;
            p.bottom = filled ? coord_t'(b) : '0;
            p.last   = 1'b0;
            return p;
        endfunction

        // Works out the pieces left of the base once the cutter is removed.
        function void note_pair(rect_pair_t x);
            int     bl, bt, br, bb, cl, ct, cr, cb;
            int     ovl_left, ovl_top, ovl_right, ovl_bottom;
            piece_t bands[$];
            piece_t p;
            bl = x.base_left;
            bt = x.base_top;
            br = x.base_right;
            bb = x.base_bottom;
            cl = x.cut_left;
            ct = x.cut_top;
            cr = x.cut_right;
            cb = x.cut_bottom;
            if (cl <= bl && ct <= bt && br <= cr && bb <= cb) begin
                p = make_piece(1'b0, 0, 0, 0, 0);
                p.last = 1'b1;
                add_expected(p);
                return;
            end
            ovl_left   = (bl > cl) ? bl : cl;
            ovl_top    = (bt > ct) ? bt : ct;
            ovl_right  = (br < cr) ? br : cr;
            ovl_bottom = (bb < cb) ? bb : cb;
            if (ovl_right - ovl_left <= 0 || ovl_bottom - ovl_top <= 0 ||
                cr == cl || cb == ct)
            begin
                p = make_piece(1'b1, bl, bt, br, bb);
                p.last = 1'b1;
                add_expected(p);
                return;
            end
            if (bt < ovl_top)
                bands.insert(bands.size(), make_piece(1'b1, bl, bt, br, ovl_top));
            if (bl < ovl_left)
                bands.insert(bands.size(),
                             make_piece(1'b1, bl, ovl_top, ovl_left, ovl_bottom));
            if (br > ovl_right)
                bands.insert(bands.size(),
                             make_piece(1'b1, ovl_right, ovl_top, br, ovl_bottom));
            if (bb > ovl_bottom)
                bands.insert(bands.size(), make_piece(1'b1, bl, ovl_bottom, br, bb));
            if (bands.size() == 0)
                bands.insert(bands.size(), make_piece(1'b0, 0, 0, 0, 0));
            bands[bands.size()-1].last = 1'b1;
            foreach (bands[i])
                add_expected(bands[i]);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_piece(piece_t got);
            piece_t want;
            if (pending_pieces.size() == 0) begin
                $error("piece: unexpected transfer, left %0d top %0d right %0d bottom %0d",
                       got.left, got.top, got.right, got.bottom);
                mismatches++;
                return;
            end
            want = pending_pieces.pop_front();
            compare("piece_left", want.left, got.left);
            compare("piece_top", want.top, got.top);
            compare("piece_right", want.right, got.right);
            compare("piece_bottom", want.bottom, got.bottom);
            compare("piece_valid", want.filled, got.filled);
            compare("last_piece", want.last, got.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;

    rect_split_scoreboard sb;

    rds_pair_if  #(.COORD_BITS(COORD_BITS)) pair_ch ();
    rds_piece_if #(.COORD_BITS(COORD_BITS)) piece_ch ();

    rectangle_difference_splitter_unit #(.COORD_BITS(COORD_BITS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pair  (pair_ch),
        .piece (piece_ch)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        piece_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        rect_pair_t x;
        piece_t     p;
        if (rst_n && pair_ch.valid && pair_ch.ready) begin
            x.base_left   = pair_ch.base_left;
            x.base_top    = pair_ch.base_top;
            x.base_right  = pair_ch.base_right;
            x.base_bottom = pair_ch.base_bottom;
            x.cut_left    = pair_ch.cut_left;
            x.cut_top     = pair_ch.cut_top;
            x.cut_right   = pair_ch.cut_right;
            x.cut_bottom  = pair_ch.cut_bottom;
            sb.note_pair(x);
        end
        if (rst_n && piece_ch.valid && piece_ch.ready) begin
            p.left   = piece_ch.piece_left;
            p.top    = piece_ch.piece_top;
            p.right  = piece_ch.piece_right;
            p.bottom = piece_ch.piece_bottom;
            p.filled = piece_ch.piece_valid;
            p.last   = piece_ch.last_piece;
            sb.check_piece(p);
        end
    end

    function automatic rect_pair_t mk_pair(int bl, int bt, int br, int bb,
                                           int cl, int ct, int cr, int cb);
        rect_pair_t x;
        x.base_left   = coord_t'(bl);
        x.base_top    = coord_t'(bt);
        x.base_right  = coord_t'(br);
        x.base_bottom = coord_t'(bb);
        x.cut_left    = coord_t'(cl);
        x.cut_top     = coord_t'(ct);
        x.cut_right   = coord_t'(cr);
        x.cut_bottom  = coord_t'(cb);
        return x;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // Most items are a small base with a cutter placed near it, so that every
    // combination of bands turns up; the rest are raw or extreme coordinates.
    function automatic rect_pair_t random_pair();
        int x0, y0, w, h, cl, ct, cr, cb;
        int mode;
        mode = $urandom_range(9);
        x0 = $urandom_range(64000) - 32000;
        y0 = $urandom_range(64000) - 32000;
        w  = $urandom_range(40);
        h  = $urandom_range(40);
        if (mode <= 1)
            return mk_pair($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        if (mode == 2)
            return mk_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        if (mode == 9)
            return mk_pair(x0, y0, x0 + w, y0 + h,
                           x0 - $urandom_range(5), y0 - $urandom_range(5),
                           x0 + w + $urandom_range(5), y0 + h + $urandom_range(5));
        cl = x0 + $urandom_range(w + 20) - 10;
        ct = y0 + $urandom_range(h + 20) - 10;
        cr = cl + $urandom_range(w + 10);
        cb = ct + $urandom_range(h + 10);
        if ($urandom_range(15) == 0)
            cr = cl - $urandom_range(5);
        return mk_pair(x0, y0, x0 + w, y0 + h, cl, ct, cr, cb);
    endfunction

    task automatic send_pair(rect_pair_t x);
        while ($urandom_range(99) < src_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pair_ch.valid       <= 1'b1;
        pair_ch.base_left   <= x.base_left;
        pair_ch.base_top    <= x.base_top;
        pair_ch.base_right  <= x.base_right;
        pair_ch.base_bottom <= x.base_bottom;
        pair_ch.cut_left    <= x.cut_left;
        pair_ch.cut_top     <= x.cut_top;
        pair_ch.cut_right   <= x.cut_right;
        pair_ch.cut_bottom  <= x.cut_bottom;
        do
            @(posedge clk);
        while (!pair_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain_pieces();
        pair_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_pieces.size() != 0);
    endtask

    task automatic send_directed();
        send_pair(mk_pair(0, 0, 10, 10, 3, 3, 7, 7));
        send_pair(mk_pair(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(mk_pair(0, 0, 10, 10, -5, -5, 20, 20));
        send_pair(mk_pair(0, 0, 10, 10, 20, 20, 30, 30));
        send_pair(mk_pair(0, 0, 10, 10, 10, 0, 20, 10));
        send_pair(mk_pair(0, 0, 10, 10, 5, 2, 5, 8));
        send_pair(mk_pair(0, 0, 10, 10, 2, 5, 8, 5));
        send_pair(mk_pair(0, 0, 10, 10, -1, 5, 11, 11));
        send_pair(mk_pair(0, 0, 10, 10, -1, -1, 11, 5));
        send_pair(mk_pair(0, 0, 10, 10, 5, -1, 11, 11));
        send_pair(mk_pair(0, 0, 10, 10, -1, -1, 5, 11));
        send_pair(mk_pair(0, 0, 10, 10, 5, 5, 11, 11));
        send_pair(mk_pair(0, 0, 10, 10, -1, -1, 5, 5));
        send_pair(mk_pair(0, 0, 10, 10, 5, 5, 3, 3));
        send_pair(mk_pair(5, 0, 5, 10, 0, 0, 3, 3));
        send_pair(mk_pair(10, 10, 0, 0, 0, 0, 20, 20));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 0, 32767, 1));
        send_pair(mk_pair(-1, -1, -1, -1, 0, 0, 0, 0));
        send_pair(mk_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    endtask

    initial
    begin
        rst_n               = 1'b0;
        src_idle_pct        = 14;
        sink_idle_pct       = 48;
        pair_ch.valid       = 1'b0;
        pair_ch.base_left   = '0;
        pair_ch.base_top    = '0;
        pair_ch.base_right  = '0;
        pair_ch.base_bottom = '0;
        pair_ch.cut_left    = '0;
        pair_ch.cut_top     = '0;
        pair_ch.cut_right   = '0;
        pair_ch.cut_bottom  = '0;
        sb = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_directed();
        // The sender holds off here until every piece so far has been seen.
        drain_pieces();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 14; sink_idle_pct = 48; end
                1: begin src_idle_pct = 48; sink_idle_pct = 14; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            repeat (160) send_pair(random_pair());
            drain_pieces();
        end
        repeat (20) @(negedge clk);

        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
